### hdl/rmsp_pkg.sv
// ----------------------------------------------------------------------------
// rmsp_pkg
// Shared widths, register codes and the sideband record of the update pipeline.
// ----------------------------------------------------------------------------
package rmsp_pkg;

    localparam int NUM_ENTRIES_DEF = 1024;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int STEP_W  = 24;
    localparam int DECAY_W = 16;
    localparam int MOM_W   = 40;
    localparam int GG_W    = 64;
    localparam int G2_W    = 48;
    localparam int DM_W    = 56;
    localparam int EG_W    = 65;
    localparam int ACC_W   = 66;
    localparam int X_W     = 57;
    localparam int ROOT_W  = 29;
    localparam int SQ_W    = 59;
    localparam int NUM_W   = 56;
    localparam int SUM_W   = 58;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 1'b1;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd655;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    localparam logic [MOM_W-1:0] MOM_MAX = {MOM_W{1'b1}};
    localparam int               EPS_LSB = 66;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] idx;
        logic             rng;
        logic             neg;
        logic [VAL_W-1:0] p;
        logic [MOM_W-1:0] mn;
        logic [NUM_W-1:0] sg;
    } side_t;

endpackage

### hdl/rmsp_ram.sv
// ----------------------------------------------------------------------------
// rmsp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rmsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/rmsp_sqrt.sv
// ----------------------------------------------------------------------------
// rmsp_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmsp_sqrt import rmsp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [X_W-1:0]    in_x,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output side_t             out_side,
    input  logic [IDX_W-1:0]  probe_idx,
    output logic              hit
);

    logic              s_valid [ROOT_W+1];
    logic [SQ_W-1:0]   s_rem   [ROOT_W+1];
    logic [ROOT_W-1:0] s_root  [ROOT_W+1];
    side_t             s_side  [ROOT_W+1];

    logic              valid_reg [ROOT_W];
    logic [SQ_W-1:0]   rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    side_t             side_reg  [ROOT_W];

    assign s_valid[0] = in_valid;
    assign s_rem[0]   = SQ_W'(in_x);
    assign s_root[0]  = '0;
    assign s_side[0]  = in_side;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [SQ_W-1:0]   trial;
        logic              ge;
        logic [SQ_W-1:0]   rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            trial     = (SQ_W'(s_root[k]) << (B + 1)) + (SQ_W'(1) << (2 * B));
            ge        = s_rem[k] >= trial;
            rem_next  = ge ? s_rem[k] - trial : s_rem[k];
            root_next = ge ? (s_root[k] | (ROOT_W'(1) << B)) : s_root[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= s_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= s_side[k];
            end
        end

        assign s_valid[k+1] = valid_reg[k];
        assign s_rem[k+1]   = rem_reg[k];
        assign s_root[k+1]  = root_reg[k];
        assign s_side[k+1]  = side_reg[k];
    end

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < ROOT_W; k++)
        begin
            hit = hit | (valid_reg[k] && (side_reg[k].idx == probe_idx));
        end
    end

    assign out_valid = s_valid[ROOT_W];
    assign out_root  = s_root[ROOT_W];
    assign out_side  = s_side[ROOT_W];

endmodule

### hdl/rmsp_div.sv
// ----------------------------------------------------------------------------
// rmsp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmsp_div import rmsp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [ROOT_W-1:0] in_den,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quot,
    output side_t             out_side,
    input  logic [IDX_W-1:0]  probe_idx,
    output logic              hit
);

    logic              s_valid [NUM_W+1];
    logic [NUM_W-1:0]  s_dq    [NUM_W+1];
    logic [ROOT_W-1:0] s_rem   [NUM_W+1];
    logic [ROOT_W-1:0] s_den   [NUM_W+1];
    side_t             s_side  [NUM_W+1];

    logic              valid_reg [NUM_W];
    logic [NUM_W-1:0]  dq_reg    [NUM_W];
    logic [ROOT_W-1:0] rem_reg   [NUM_W];
    logic [ROOT_W-1:0] den_reg   [NUM_W];
    side_t             side_reg  [NUM_W];

    assign s_valid[0] = in_valid;
    assign s_dq[0]    = in_num;
    assign s_rem[0]   = '0;
    assign s_den[0]   = in_den;
    assign s_side[0]  = in_side;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [ROOT_W:0]   sh;
        logic [ROOT_W:0]   diff;
        logic              ge;
        logic [ROOT_W-1:0] rem_next;
        logic [NUM_W-1:0]  dq_next;

        always_comb
        begin
            sh       = {s_rem[k], s_dq[k][NUM_W-1]};
            ge       = sh >= {1'b0, s_den[k]};
            diff     = sh - {1'b0, s_den[k]};
            rem_next = ge ? diff[ROOT_W-1:0] : sh[ROOT_W-1:0];
            dq_next  = {s_dq[k][NUM_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= s_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg[k]   <= dq_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= s_den[k];
                side_reg[k] <= s_side[k];
            end
        end

        assign s_valid[k+1] = valid_reg[k];
        assign s_dq[k+1]    = dq_reg[k];
        assign s_rem[k+1]   = rem_reg[k];
        assign s_den[k+1]   = den_reg[k];
        assign s_side[k+1]  = side_reg[k];
    end

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < NUM_W; k++)
        begin
            hit = hit | (valid_reg[k] && (side_reg[k].idx == probe_idx));
        end
    end

    assign out_valid = s_valid[NUM_W];
    assign out_quot  = s_dq[NUM_W];
    assign out_side  = s_side[NUM_W];

endmodule

### hdl/rmsprop_parameter_update_core.sv
// ----------------------------------------------------------------------------
// rmsprop_parameter_update_core
// RMSprop update of per-entry parameters with stored second moments.
//
// One transaction enters per clock while the output does not stall. The path
// from acceptance to result is the memory read, two multiply stages, the
// moment sum, 29 stages of square root, one rounding add, 56 stages of
// division and the output register. The parameter and moment memories are
// read when a transaction is accepted and written when it reaches the output
// register, so a transaction whose entry is still in flight is held at the
// input until the earlier one for that entry is written back. The memories
// are not cleared after reset; an entry must be loaded before it is updated.
// ----------------------------------------------------------------------------
module rmsprop_parameter_update_core import rmsp_pkg::*; #(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    mode,
    input  logic [IDX_W-1:0]        entry_index,
    input  logic signed [VAL_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [IDX_W-1:0]        entry_index_res,
    output logic signed [VAL_W-1:0] parameter_value
);

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic [STEP_W-1:0]  step_reg;
    logic [DECAY_W-1:0] decay_reg;

    logic adv;
    logic accept;
    logic hit_any;
    logic sqrt_hit;
    logic div_hit;

    logic [31:0]   idx_ext;
    logic [AW-1:0] rd_addr;

    // stage a: memory read
    logic                    a_valid_reg;
    logic                    a_mode_reg;
    logic [IDX_W-1:0]        a_idx_reg;
    logic                    a_rng_reg;
    logic signed [VAL_W-1:0] a_value_reg;
    logic [VAL_W-1:0]        ram_p;
    logic [MOM_W-1:0]        ram_m;
    logic                    a_neg;
    logic [VAL_W-1:0]        a_mag;
    logic [GG_W-1:0]         a_gg;
    logic [NUM_W-1:0]        a_sg;
    side_t                   a_side;

    // stage b: squared gradient and step product
    logic             b_valid_reg;
    side_t            b_side_reg;
    logic [GG_W-1:0]  b_gg_reg;
    logic [MOM_W-1:0] b_m_reg;
    logic [G2_W-1:0]  b_g2;
    logic [DM_W-1:0]  b_dm;
    logic [DECAY_W:0] b_omd;
    logic [EG_W-1:0]  b_eg;

    // stage c: moment terms
    logic             c_valid_reg;
    side_t            c_side_reg;
    logic [DM_W-1:0]  c_dm_reg;
    logic [EG_W-1:0]  c_eg_reg;
    logic [ACC_W-1:0] c_acc;
    logic [ACC_W-17:0] c_mn_raw;
    logic [MOM_W-1:0] c_mn;
    logic [MOM_W:0]   c_mn_eps;
    side_t            c_side;

    // stage d: square root operand
    logic            d_valid_reg;
    side_t           d_side_reg;
    logic [X_W-1:0]  d_x_reg;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    // stage e: rounded dividend
    logic              e_valid_reg;
    side_t             e_side_reg;
    logic [NUM_W-1:0]  e_num_reg;
    logic [ROOT_W-1:0] e_den_reg;

    logic             dv_valid;
    logic [NUM_W-1:0] dv_quot;
    side_t            dv_side;

    // stage f: parameter update and write-back
    logic signed [SUM_W-1:0] f_p;
    logic signed [SUM_W-1:0] f_q;
    logic signed [SUM_W-1:0] f_sum;
    logic [VAL_W-1:0]        f_upd;
    logic [VAL_W-1:0]        f_res;
    logic                    wr_en;
    logic [31:0]             wr_idx_ext;

    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic [VAL_W-1:0]        out_param_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_RESET;
            decay_reg <= DECAY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STEP:  step_reg  <= cfg_data[STEP_W-1:0];
                REG_DECAY: decay_reg <= cfg_data[DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        hit_any = sqrt_hit || div_hit
               || (a_valid_reg && (a_idx_reg == entry_index))
               || (b_valid_reg && (b_side_reg.idx == entry_index))
               || (c_valid_reg && (c_side_reg.idx == entry_index))
               || (d_valid_reg && (d_side_reg.idx == entry_index))
               || (e_valid_reg && (e_side_reg.idx == entry_index));
    end

    assign in_ready = adv && !hit_any;
    assign accept   = in_valid && in_ready;

    assign idx_ext = 32'(entry_index);
    assign rd_addr = idx_ext[AW-1:0];

    rmsp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_ENTRIES)
    ) u_param_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx_ext[AW-1:0]),
        .wdata (f_res),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (ram_p)
    );

    rmsp_ram #(
        .WIDTH (MOM_W),
        .DEPTH (NUM_ENTRIES)
    ) u_moment_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx_ext[AW-1:0]),
        .wdata (dv_side.mn),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (ram_m)
    );

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= accept;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= sq_valid;
            out_valid_reg <= dv_valid;
        end
    end

    // stage a
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_mode_reg  <= mode;
            a_idx_reg   <= entry_index;
            a_rng_reg   <= idx_ext < NUM_ENTRIES;
            a_value_reg <= value;
        end
    end

    always_comb
    begin
        a_neg       = a_value_reg[VAL_W-1];
        a_mag       = a_neg ? VAL_W'(-a_value_reg) : VAL_W'(a_value_reg);
        a_gg        = a_mag * a_mag;
        a_sg        = step_reg * a_mag;
        a_side.mode = a_mode_reg;
        a_side.idx  = a_idx_reg;
        a_side.rng  = a_rng_reg;
        a_side.neg  = a_neg;
        a_side.p    = (a_mode_reg == MODE_LOAD) ? VAL_W'(a_value_reg) : ram_p;
        a_side.mn   = '0;
        a_side.sg   = a_sg;
    end

    // stage b
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_side_reg <= a_side;
            b_gg_reg   <= a_gg;
            b_m_reg    <= ram_m;
        end
    end

    always_comb
    begin
        b_g2  = b_gg_reg[GG_W-1:16];
        b_dm  = decay_reg * b_m_reg;
        b_omd = (DECAY_W+1)'(1 << DECAY_W) - (DECAY_W+1)'(decay_reg);
        b_eg  = b_omd * b_g2;
    end

    // stage c
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_side_reg <= b_side_reg;
            c_dm_reg   <= b_dm;
            c_eg_reg   <= b_eg;
        end
    end

    always_comb
    begin
        c_acc    = ACC_W'(c_dm_reg) + ACC_W'(c_eg_reg) + ACC_W'(32768);
        c_mn_raw = c_acc[ACC_W-1:16];
        if (c_side_reg.mode == MODE_LOAD)
        begin
            c_mn = '0;
        end
        else if (c_mn_raw > (ACC_W-16)'(MOM_MAX))
        begin
            c_mn = MOM_MAX;
        end
        else
        begin
            c_mn = c_mn_raw[MOM_W-1:0];
        end
        c_mn_eps  = (MOM_W+1)'(c_mn) + (MOM_W+1)'(EPS_LSB);
        c_side    = c_side_reg;
        c_side.mn = c_mn;
    end

    // stage d
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_side_reg <= c_side;
            d_x_reg    <= {c_mn_eps, 16'h0000};
        end
    end

    rmsp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .in_x      (d_x_reg),
        .in_side   (d_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side),
        .probe_idx (entry_index),
        .hit       (sqrt_hit)
    );

    // stage e
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_side_reg <= sq_side;
            e_num_reg  <= sq_side.sg + NUM_W'(sq_root >> 1);
            e_den_reg  <= sq_root;
        end
    end

    rmsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (e_valid_reg),
        .in_num    (e_num_reg),
        .in_den    (e_den_reg),
        .in_side   (e_side_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side),
        .probe_idx (entry_index),
        .hit       (div_hit)
    );

    // stage f
    always_comb
    begin
        f_p   = SUM_W'(signed'(dv_side.p));
        f_q   = signed'({2'b00, dv_quot});
        f_sum = dv_side.neg ? (f_p + f_q) : (f_p - f_q);
        if (f_sum > SUM_W'(64'sd2147483647))
        begin
            f_upd = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (f_sum < -SUM_W'(64'sd2147483648))
        begin
            f_upd = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            f_upd = f_sum[VAL_W-1:0];
        end

        if (!dv_side.rng)
        begin
            f_res = '0;
        end
        else if (dv_side.mode == MODE_LOAD)
        begin
            f_res = dv_side.p;
        end
        else
        begin
            f_res = f_upd;
        end
    end

    assign wr_en      = adv && dv_valid && dv_side.rng;
    assign wr_idx_ext = 32'(dv_side.idx);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_idx_reg   <= dv_side.idx;
            out_param_reg <= f_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign entry_index_res = out_idx_reg;
    assign parameter_value = signed'(out_param_reg);

endmodule

### hdl/rmsp_checker.sv
// ----------------------------------------------------------------------------
// rmsp_checker
// Port-level checks of the update core, bound to the top level.
// ----------------------------------------------------------------------------
module rmsp_checker import rmsp_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [IDX_W-1:0]        entry_index,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [IDX_W-1:0]        entry_index_res,
    input logic signed [VAL_W-1:0] parameter_value
);

    // held result transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_index_res)
            && $stable(parameter_value))
        else $error("result changed while stalled");

    // a stalled output stops the input
    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // same entry cannot follow directly
    a_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=>
            !(in_valid && in_ready && (entry_index == $past(entry_index))))
        else $error("same entry accepted while in flight");

endmodule

bind rmsprop_parameter_update_core rmsp_checker u_rmsp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .entry_index     (entry_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .entry_index_res (entry_index_res),
    .parameter_value (parameter_value)
);

### tb/rmsprop_parameter_update_checker.sv
// ----------------------------------------------------------------------------
// rmsprop_parameter_update_checker
// Watches the configuration port and both channels of the update core. Every
// accepted update is run through a fixed-point model of the RMSprop update,
// with its own copies of the parameter and moment memories, which a load sets
// directly. The predicted parameter is queued. Each accepted output
// transaction is compared against the oldest queued prediction.
// ----------------------------------------------------------------------------
module rmsprop_parameter_update_checker import rmsp_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    mode,
    input  logic [IDX_W-1:0]        entry_index,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [IDX_W-1:0]        entry_index_res,
    input  logic signed [VAL_W-1:0] parameter_value,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] param;
    } param_result_t;

    logic [VAL_W-1:0]   param_mirror [NUM_ENTRIES_DEF];
    logic [MOM_W-1:0]   moment_mirror [NUM_ENTRIES_DEF];
    logic [STEP_W-1:0]  step_q;
    logic [DECAY_W-1:0] decay_q;
    param_result_t      expected_params [$];

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 64'd0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] saturate32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic [VAL_W-1:0] apply_gradient(logic [IDX_W-1:0] idx,
                                                        logic [VAL_W-1:0] g);
        logic               neg;
        logic [63:0]        mag_g;
        logic [63:0]        g2;
        logic [79:0]        acc;
        logic [79:0]        mn;
        logic [63:0]        root;
        logic [63:0]        num;
        logic [63:0]        delta;
        logic signed [63:0] p;
        neg = g[31];
        mag_g = neg ? (64'd0 - {{32{g[31]}}, g}) : {32'd0, g};
        g2 = (mag_g * mag_g) >> 16;
        acc = 80'(decay_q) * 80'(moment_mirror[idx])
            + (80'd65536 - 80'(decay_q)) * 80'(g2) + 80'd32768;
        mn = acc >> 16;
        if (mn > 80'(MOM_MAX))
            mn = 80'(MOM_MAX);
        moment_mirror[idx] = mn[MOM_W-1:0];
        root = isqrt64((mn[63:0] + 64'(EPS_LSB)) << 16);
        num = 64'(step_q) * mag_g;
        delta = (num + (root >> 1)) / root;
        p = {{32{param_mirror[idx][31]}}, param_mirror[idx]};
        p = neg ? p + $signed(delta) : p - $signed(delta);
        param_mirror[idx] = saturate32(p);
        return param_mirror[idx];
    endfunction

    task automatic report(string what, longint expv, longint gotv);
        $display("mismatch %s: expected %0d got %0d", what, expv, gotv);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        param_result_t pr;
        param_result_t head;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES_DEF; i++)
            begin
                param_mirror[i] = '0;
                moment_mirror[i] = '0;
            end
            step_q = STEP_RESET;
            decay_q = DECAY_RESET;
            expected_params.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_STEP)
                    step_q = cfg_data[STEP_W-1:0];
                else if (cfg_index == REG_DECAY)
                    decay_q = cfg_data[DECAY_W-1:0];
            end
            if (out_valid && out_ready)
            begin
                if (expected_params.size() == 0)
                begin
                    report("unexpected output transaction, index", -1, entry_index_res);
                end
                else
                begin
                    head = expected_params.pop_front();
                    if (entry_index_res !== head.idx)
                        report("entry_index_res", head.idx, entry_index_res);
                    if (parameter_value !== head.param)
                        report("parameter_value", $signed(head.param),
                               parameter_value);
                end
            end
            if (in_valid && in_ready)
            begin
                pr.idx = entry_index;
                if (mode == MODE_LOAD)
                begin
                    param_mirror[entry_index] = value;
                    moment_mirror[entry_index] = '0;
                    pr.param = value;
                end
                else
                begin
                    pr.param = apply_gradient(entry_index, value);
                end
                expected_params.push_back(pr);
            end
            pending = expected_params.size();
        end
    end

endmodule

### tb/rmsprop_parameter_update_core_tb.sv
// ----------------------------------------------------------------------------
// rmsprop_parameter_update_core_tb
// Stimulus and verdict for the RMSprop update core. Directed loads and
// gradient extremes come first, then random loads and updates in phases under
// several step and decay settings, all but the last with idle bursts on the
// input and stalls on the output. A separate checker predicts every result.
// ----------------------------------------------------------------------------
module rmsprop_parameter_update_core_tb;
    import rmsp_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int DRAIN_CYCLES = 120;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    mode;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] value;
    logic                    out_valid;
    logic                    out_ready;
    logic [IDX_W-1:0]        entry_index_res;
    logic signed [VAL_W-1:0] parameter_value;
    int                      fail_count;
    int                      pending;
    int                      cycle_count;
    bit                      idle_en;
    int                      stall_left;
    bit                      loaded [NUM_ENTRIES_DEF];
    logic [IDX_W-1:0]        loaded_list [$];
    logic [IDX_W-1:0]        hot_set [$];

    rmsprop_parameter_update_core dut (.*);

    rmsprop_parameter_update_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // output stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic send(logic m, logic [IDX_W-1:0] i, logic [VAL_W-1:0] v);
        bit taken;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        entry_index <= i;
        value <= v;
        if (m == MODE_LOAD && !loaded[i])
        begin
            loaded[i] = 1'b1;
            loaded_list.push_back(i);
        end
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic write_regs(logic [STEP_W-1:0] step, logic [DECAY_W-1:0] decay);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_STEP;
        cfg_data <= CFG_DATA_W'(step);
        @(posedge clk);
        cfg_index <= REG_DECAY;
        cfg_data <= CFG_DATA_W'(decay);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 131072)) - 65536);
            3: return 32'($signed($urandom_range(0, 8388608)) - 4194304);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [IDX_W-1:0] i;
        for (int n = 0; n < count; n++)
        begin
            if (loaded_list.size() == 0 || $urandom_range(0, 9) < 3)
            begin
                i = IDX_W'($urandom_range(0, NUM_ENTRIES_DEF - 1));
                if ($urandom_range(0, 3) == 0 && hot_set.size() > 0)
                    i = hot_set[$urandom_range(0, hot_set.size() - 1)];
                send(MODE_LOAD, i, pick_value());
                if (hot_set.size() < 8)
                    hot_set.push_back(i);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    i = hot_set[$urandom_range(0, hot_set.size() - 1)];
                else
                    i = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                send(MODE_UPDATE, i, pick_value());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_STEP;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = MODE_LOAD;
        entry_index = '0;
        value = '0;
        out_ready = 1'b0;
        cycle_count = 0;
        stall_left = 0;
        idle_en = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: load extremes, then gradient extremes on loaded entries
        send(MODE_LOAD, 10'd0, 32'h7fffffff);
        send(MODE_LOAD, 10'd1023, 32'h80000000);
        send(MODE_LOAD, 10'd512, 32'd0);
        send(MODE_LOAD, 10'd341, 32'h00010000);
        send(MODE_UPDATE, 10'd0, 32'h80000000);
        send(MODE_UPDATE, 10'd0, 32'h80000000);
        send(MODE_UPDATE, 10'd1023, 32'h7fffffff);
        send(MODE_UPDATE, 10'd1023, 32'h7fffffff);
        send(MODE_UPDATE, 10'd512, 32'd0);
        send(MODE_UPDATE, 10'd341, 32'h00010000);
        send(MODE_UPDATE, 10'd341, 32'hffff0000);
        send(MODE_UPDATE, 10'd341, 32'h00000001);
        send(MODE_LOAD, 10'd341, 32'hfffffff0);
        send(MODE_UPDATE, 10'd341, 32'hffffffff);

        // zero decay, largest step
        write_regs(24'hffffff, 16'd0);
        send(MODE_UPDATE, 10'd0, 32'h7fffffff);
        send(MODE_UPDATE, 10'd512, 32'h80000000);
        send(MODE_UPDATE, 10'd1023, 32'h80000000);
        send(MODE_UPDATE, 10'd341, 32'h00000100);
        // zero step, largest decay
        write_regs(24'd0, 16'hffff);
        send(MODE_UPDATE, 10'd0, 32'h7fffffff);
        send(MODE_UPDATE, 10'd341, 32'h80000000);

        idle_en = 1'b1;
        write_regs(STEP_RESET, DECAY_RESET);
        random_phase(300);
        write_regs(24'hffffff, 16'd0);
        random_phase(200);
        write_regs(24'd0, 16'hffff);
        random_phase(150);
        write_regs(STEP_W'($urandom_range(0, 24'hffffff)),
                   DECAY_W'($urandom_range(0, 16'hffff)));
        random_phase(250);
        write_regs(STEP_W'($urandom_range(1, 4096)),
                   DECAY_W'($urandom_range(32768, 65535)));
        random_phase(150);
        idle_en = 1'b0;
        write_regs(STEP_W'($urandom_range(0, 24'hffffff)),
                   DECAY_W'($urandom_range(0, 16'hffff)));
        random_phase(200);
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
hdl/rmsp_pkg.sv
hdl/rmsp_ram.sv
hdl/rmsp_sqrt.sv
hdl/rmsp_div.sv
hdl/rmsprop_parameter_update_core.sv
hdl/rmsp_checker.sv
tb/rmsprop_parameter_update_checker.sv
tb/rmsprop_parameter_update_core_tb.sv
